[design/bblur_pkg.sv]
// Shared constants and types for the 3x3 box blur.
`timescale 1ns / 1ps

package bblur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W    = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef logic [PIX_W-1:0] chan_t;
    typedef logic [3*PIX_W-1:0] rgb_t;

endpackage

[design/box_blur_3x3_top.sv]
// Streaming 3x3 box blur with two line buffers held in one block memory.
`timescale 1ns / 1ps

// Takes one RGB pixel per item in raster order and returns the rounded mean of
// each pixel's in-frame 3x3 neighbourhood as soon as it is complete, zero to four
// results per item, last_of_run marking the final one. The block handles one item
// at a time: an item goes through the line-buffer read and write-back of its
// column, then each result through window sum, divide-by-constant multiply and
// output register, plus any wait on m_ready. Both line buffers live in a single
// 1024 x 48 memory; entries are never cleared, reads of rows outside the frame
// are masked out. Writing frame_width or frame_height restarts the frame.
module box_blur_3x3_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bblur_pkg::chan_t                 s_in_red,
    input  bblur_pkg::chan_t                 s_in_green,
    input  bblur_pkg::chan_t                 s_in_blue,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bblur_pkg::ROW_W-1:0]      m_out_row,
    output logic [bblur_pkg::COL_W-1:0]      m_out_col,
    output bblur_pkg::chan_t                 m_out_red,
    output bblur_pkg::chan_t                 m_out_green,
    output bblur_pkg::chan_t                 m_out_blue,
    output logic                             m_last_of_run
);
    import bblur_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    localparam int SUM_W  = 12;
    localparam int X_W    = 13;
    localparam int K_W    = 16;
    localparam int PROD_W = SUM_W + K_W;
    localparam int Q_SH   = 15;

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ROW_W-1:0]    row_pos_reg;
    logic [COL_W-1:0]    col_pos_reg;

    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    rgb_t                pix_reg;
    logic [2*3*PIX_W-1:0] rd_data_reg;
    rgb_t                win_reg [9];
    logic [3:0]          pend_reg;

    logic [SUM_W-1:0]    sum_r_reg, sum_g_reg, sum_b_reg;
    logic [3:0]          n_reg;

    logic [ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    chan_t               out_r_reg, out_g_reg, out_b_reg;
    logic                last_reg;

    logic [2*3*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]    c_use;
    logic [ROW_W-1:0]    r_use;
    logic                accept, cfg_write;
    logic                last_col, last_row;
    logic [3:0]          pend_new;
    logic [3:0]          sel;
    logic                up_row, left_col;
    logic [2:0]          rmask, cmask;
    logic [1:0]          nr, nc;
    logic [SUM_W-1:0]    sr, sg, sb;

    function automatic chan_t div_round(input logic [SUM_W-1:0] sum, input logic [3:0] n);
        logic [X_W-1:0]    x;
        logic [SUM_W-1:0]  y;
        logic [K_W-1:0]    k;
        logic [PROD_W-1:0] p;
        x = {sum, 1'b0} + X_W'(n);
        if (n == 4'd2 || n == 4'd6) begin
            y = SUM_W'(x >> 2);
        end else if (n == 4'd4) begin
            y = SUM_W'(x >> 3);
        end else begin
            y = SUM_W'(x >> 1);
        end
        if (n == 4'd3 || n == 4'd6) begin
            k = K_W'(10923);
        end else if (n == 4'd9) begin
            k = K_W'(3641);
        end else begin
            k = K_W'(32768);
        end
        p = PROD_W'(y) * PROD_W'(k);
        return p[Q_SH+PIX_W-1:Q_SH];
    endfunction

    assign w_eff = (width_reg == '0) ? WIDTH_W'(1) :
                   (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HEIGHT_W'(1) :
                   (height_reg > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_reg;

    assign c_use = ({1'b0, col_pos_reg} >= w_eff) ? '0 : col_pos_reg;
    assign r_use = ({1'b0, row_pos_reg} >= h_eff) ? '0 : row_pos_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_write = cfg_valid && cfg_ready;

    assign last_col = ({1'b0, col_reg} == w_eff - WIDTH_W'(1));
    assign last_row = ({1'b0, row_reg} == h_eff - HEIGHT_W'(1));

    assign pend_new = {last_row && last_col,
                       last_row && (col_reg != '0),
                       (row_reg != '0) && last_col,
                       (row_reg != '0) && (col_reg != '0)};

    // lowest pending slot: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
    assign sel[0] = pend_reg[0];
    assign sel[1] = !pend_reg[0] && pend_reg[1];
    assign sel[2] = !pend_reg[0] && !pend_reg[1] && pend_reg[2];
    assign sel[3] = !pend_reg[0] && !pend_reg[1] && !pend_reg[2];
    assign up_row   = sel[0] || sel[1];
    assign left_col = sel[0] || sel[2];

    always_comb begin
        if (up_row) begin
            rmask = {1'b1, 1'b1, row_reg >= ROW_W'(2)};
        end else begin
            rmask = {1'b1, row_reg != '0, 1'b0};
        end
        if (left_col) begin
            cmask = {1'b1, 1'b1, col_reg >= COL_W'(2)};
        end else begin
            cmask = {1'b1, col_reg != '0, 1'b0};
        end
        nr = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
        nc = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    end

    always_comb begin
        sr = '0;
        sg = '0;
        sb = '0;
        for (int i = 0; i < 9; i++) begin
            if (rmask[i / 3] && cmask[i % 3]) begin
                sr = sr + SUM_W'(win_reg[i][3*PIX_W-1:2*PIX_W]);
                sg = sg + SUM_W'(win_reg[i][2*PIX_W-1:PIX_W]);
                sb = sb + SUM_W'(win_reg[i][PIX_W-1:0]);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ: state_next = (pend_new != '0) ? S_SUM : S_IDLE;
            S_SUM:  state_next = S_DIV;
            S_DIV:  state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = (pend_reg != '0) ? S_SUM : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            width_reg   <= WIDTH_W'(1024);
            height_reg  <= HEIGHT_W'(1024);
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            pend_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg   <= cfg_data[WIDTH_W-1:0];
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg  <= cfg_data[HEIGHT_W-1:0];
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == S_READ) begin
                pend_reg <= pend_new;
                if (last_col) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_pos_reg <= col_reg + COL_W'(1);
                    row_pos_reg <= row_reg;
                end
            end
            if (state_reg == S_SUM) begin
                pend_reg <= pend_reg & ~sel;
            end
        end
    end

    // line memory: word is {two rows up, one row up} for a column
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[c_use];
        end
        if (state_reg == S_READ) begin
            line_mem[col_reg] <= {rd_data_reg[3*PIX_W-1:0], pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            row_reg <= r_use;
            col_reg <= c_use;
            pix_reg <= {s_in_red, s_in_green, s_in_blue};
        end
        if (state_reg == S_READ) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= rd_data_reg[2*3*PIX_W-1:3*PIX_W];
            win_reg[5] <= rd_data_reg[3*PIX_W-1:0];
            win_reg[8] <= pix_reg;
        end
        if (state_reg == S_SUM) begin
            sum_r_reg   <= sr;
            sum_g_reg   <= sg;
            sum_b_reg   <= sb;
            n_reg       <= 4'(nr) * 4'(nc);
            out_row_reg <= up_row ? row_reg - ROW_W'(1) : row_reg;
            out_col_reg <= left_col ? col_reg - COL_W'(1) : col_reg;
            last_reg    <= ((pend_reg & ~sel) == '0);
        end
        if (state_reg == S_DIV) begin
            out_r_reg <= div_round(sum_r_reg, n_reg);
            out_g_reg <= div_round(sum_g_reg, n_reg);
            out_b_reg <= div_round(sum_b_reg, n_reg);
        end
    end

    assign m_valid       = (state_reg == S_OUT);
    assign m_out_row     = out_row_reg;
    assign m_out_col     = out_col_reg;
    assign m_out_red     = out_r_reg;
    assign m_out_green   = out_g_reg;
    assign m_out_blue    = out_b_reg;
    assign m_last_of_run = last_reg;

endmodule

[design/bblur_checker.sv]
// Port-level checks for the box blur top level, bound to it.
`timescale 1ns / 1ps

module bblur_props (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bblur_pkg::ROW_W-1:0] m_out_row,
    input logic [bblur_pkg::COL_W-1:0] m_out_col,
    input bblur_pkg::chan_t            m_out_red,
    input bblur_pkg::chan_t            m_out_green,
    input bblur_pkg::chan_t            m_out_blue,
    input logic                        m_last_of_run
);
    import bblur_pkg::*;

    // one item in flight: no new item while a result is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // after an item is taken, input is closed in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened right after accept");

    // last result of a run ends the burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> !m_valid)
        else $error("result after last_of_run");

    // stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_out_red) && $stable(m_out_green) && $stable(m_out_blue)
            && $stable(m_last_of_run)))
        else $error("stalled result changed");

endmodule

bind box_blur_3x3_top bblur_props u_bblur_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_row     (m_out_row),
    .m_out_col     (m_out_col),
    .m_out_red     (m_out_red),
    .m_out_green   (m_out_green),
    .m_out_blue    (m_out_blue),
    .m_last_of_run (m_last_of_run)
);

[dv/bblur_checker.sv]
// Checker for the 3x3 box blur: predicts blurred pixels from accepted items and compares.
`timescale 1ns / 1ps

module bblur_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  bblur_pkg::chan_t                  s_in_red,
    input  bblur_pkg::chan_t                  s_in_green,
    input  bblur_pkg::chan_t                  s_in_blue,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [bblur_pkg::ROW_W-1:0]       m_out_row,
    input  logic [bblur_pkg::COL_W-1:0]       m_out_col,
    input  bblur_pkg::chan_t                  m_out_red,
    input  bblur_pkg::chan_t                  m_out_green,
    input  bblur_pkg::chan_t                  m_out_blue,
    input  logic                              m_last_of_run,
    output int                                errors,
    output int                                pending,
    output int                                pixels_seen,
    output int                                results_seen
);
    import bblur_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        chan_t            red;
        chan_t            green;
        chan_t            blue;
        logic             last_of_run;
    } blur_px_t;

    blur_px_t            blur_q[$];
    rgb_t                row_up2[MAX_WIDTH];
    rgb_t                row_up1[MAX_WIDTH];
    rgb_t                win[9];
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    int unsigned         row_pos;
    int unsigned         col_pos;

    function automatic int unsigned cols_in_frame();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned rows_in_frame();
        if (height_reg == '0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    // mean of the in-frame part of (orow, ocol)'s neighborhood; window spans r-2..r, c-2..c
    function automatic blur_px_t blur_at(int orow, int ocol, int r, int c, int w, int h);
        int       sr, sg, sb, n, dr, dc, pr, pc, wr, wc;
        rgb_t     px;
        blur_px_t o;
        sr = 0;
        sg = 0;
        sb = 0;
        n  = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                pr = orow + dr;
                pc = ocol + dc;
                wr = pr - (r - 2);
                wc = pc - (c - 2);
                if (pr >= 0 && pr < h && pc >= 0 && pc < w &&
                    wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
                    px = win[wr * 3 + wc];
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    n++;
                end
            end
        end
        o.row         = ROW_W'(orow);
        o.col         = COL_W'(ocol);
        o.red         = (n == 0) ? '0 : chan_t'((2 * sr + n) / (2 * n));
        o.green       = (n == 0) ? '0 : chan_t'((2 * sg + n) / (2 * n));
        o.blue        = (n == 0) ? '0 : chan_t'((2 * sb + n) / (2 * n));
        o.last_of_run = 1'b0;
        return o;
    endfunction

    task automatic take_pixel(input rgb_t pix);
        int unsigned w, h, r, c;
        rgb_t        up2, up1;
        logic        last_col, last_row;
        blur_px_t    run[$];
        int          i;
        w = cols_in_frame();
        h = rows_in_frame();
        r = row_pos;
        c = col_pos;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        up2 = row_up2[c];
        up1 = row_up1[c];
        row_up2[c] = up1;
        row_up1[c] = pix;
        for (i = 0; i < 3; i++) begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        if (r >= 1 && c >= 1) run.push_back(blur_at(r - 1, c - 1, r, c, w, h));
        if (r >= 1 && last_col) run.push_back(blur_at(r - 1, c, r, c, w, h));
        if (last_row && c >= 1) run.push_back(blur_at(r, c - 1, r, c, w, h));
        if (last_row && last_col) run.push_back(blur_at(r, c, r, c, w, h));
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[j]) blur_q.push_back(run[j]);
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        pixels_seen++;
    endtask

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result();
        blur_px_t want;
        results_seen++;
        if (blur_q.size() == 0) begin
            $error("unexpected blurred pixel at row %0d col %0d", m_out_row, m_out_col);
            errors++;
            return;
        end
        want = blur_q.pop_front();
        errors += field_diff("out_row", want.row, m_out_row)
                + field_diff("out_col", want.col, m_out_col)
                + field_diff("out_red", want.red, m_out_red)
                + field_diff("out_green", want.green, m_out_green)
                + field_diff("out_blue", want.blue, m_out_blue)
                + field_diff("last_of_run", want.last_of_run, m_last_of_run);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    = WIDTH_W'(1024);
            height_reg   = HEIGHT_W'(1024);
            row_pos      = 0;
            col_pos      = 0;
            errors       = 0;
            pixels_seen  = 0;
            results_seen = 0;
            blur_q.delete();
            foreach (win[i]) win[i] = '0;
            foreach (row_up2[i]) begin
                row_up2[i] = '0;
                row_up1[i] = '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = cfg_data[WIDTH_W-1:0];
                    row_pos   = 0;
                    col_pos   = 0;
                end else if (cfg_index == CFG_FRAME_HEIGHT) begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                    row_pos    = 0;
                    col_pos    = 0;
                end
            end
            if (s_valid && s_ready) take_pixel({s_in_red, s_in_green, s_in_blue});
            if (m_valid && m_ready) check_result();
        end
        pending = blur_q.size();
    end

endmodule

[dv/tb.sv]
// Testbench top for box_blur_3x3_top: stimulus, flow control, checker hookup and verdict.
`timescale 1ns / 1ps

module tb;
    import bblur_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_RSVD_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RSVD_3 = 2'd3;

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    chan_t                  s_in_red   = '0;
    chan_t                  s_in_green = '0;
    chan_t                  s_in_blue  = '0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [ROW_W-1:0]       m_out_row;
    logic [COL_W-1:0]       m_out_col;
    chan_t                  m_out_red;
    chan_t                  m_out_green;
    chan_t                  m_out_blue;
    logic                   m_last_of_run;

    int errors, pending, pixels_seen, results_seen;
    int send_idle  = 0;
    int recv_idle  = 0;
    int hold_asked = 0;
    int hold_seen;
    int hold_cnt;
    int reg_writes = 0;
    int cycles     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    box_blur_3x3_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_last_of_run (m_last_of_run)
    );

    bblur_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_red      (s_in_red),
        .s_in_green    (s_in_green),
        .s_in_blue     (s_in_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_last_of_run (m_last_of_run),
        .errors        (errors),
        .pending       (pending),
        .pixels_seen   (pixels_seen),
        .results_seen  (results_seen)
    );

    // result side: random stalls plus a single long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_cnt  <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("box_blur_3x3_top verification failed");
            $finish;
        end
    end

    function automatic chan_t rand_chan();
        if ($urandom_range(7) == 0) return ($urandom_range(1) != 0) ? 8'hff : 8'h00;
        return chan_t'($urandom_range(255));
    endfunction

    task automatic push_pixel(input chan_t red, input chan_t green, input chan_t blue);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_red   <= red;
        s_in_green <= green;
        s_in_blue  <= blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic push_random(input int count);
        repeat (count) push_pixel(rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // wait until every predicted pixel is out and the block has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        set_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        set_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic random_frames(input int quota);
        int sent, w, h, total;
        sent = 0;
        while (sent < quota) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            // junk above the width register's top bit must be dropped
            set_frame(w | ($urandom_range(3) << WIDTH_W), h);
            if ($urandom_range(9) == 0) begin
                set_reg(($urandom_range(1) != 0) ? CFG_RSVD_2 : CFG_RSVD_3,
                        CFG_DATA_W'($urandom));
            end
            total = ($urandom_range(3) == 0) ? 2 * w * h : w * h;
            if ($urandom_range(7) == 0) total = $urandom_range(0, w * h - 1);
            push_random(total);
            sent += total;
        end
    endtask

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: top row only, nothing comes out
        repeat (3) push_pixel(8'hff, 8'h00, 8'h80);
        // zero sizes act as a single pixel frame
        set_frame(0, 0);
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hff, 8'hff, 8'hff);
        set_frame(3, 3);
        for (i = 0; i < 9; i++) begin
            push_pixel(i[0] ? 8'hff : 8'h00, i[1] ? 8'hff : 8'h01, chan_t'(i * 31));
        end
        // unused register indexes must not restart the frame
        set_frame(2, 2);
        push_random(2);
        settle();
        set_reg(CFG_RSVD_2, '1);
        set_reg(CFG_RSVD_3, '0);
        push_random(2);
        // oversize registers clamp to the maximum frame
        set_frame(13'h1fff, 13'h1fff);
        push_random(3);

        send_idle = 37;
        recv_idle = 68;
        random_frames(100);
        send_idle = 68;
        recv_idle = 37;
        random_frames(100);
        send_idle = 0;
        recv_idle = 0;
        set_frame(8, 6);
        hold_asked <= hold_asked + 1;
        push_random(48);
        random_frames(100);
        set_frame(MAX_WIDTH, 1);
        push_random(40);
        set_frame(1, MAX_HEIGHT);
        push_random(40);
        settle();

        $display("Pixels sent: %0d, blurred pixels checked: %0d, register writes: %0d",
                 pixels_seen, results_seen, reg_writes);
        $display("Frames from 1x1 to 40 wide, partial full-width and full-height frames, three stall mixes");
        if (errors == 0 && pending == 0) begin
            $display("box_blur_3x3_top verification clean");
        end else begin
            $display("box_blur_3x3_top verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/bblur_pkg.sv
design/box_blur_3x3_top.sv
design/bblur_checker.sv
dv/bblur_checker.sv
dv/tb.sv
